>>> sv/led_mode_blink_controller_unit_macros.svh
// Assertion macros for the LED blink controller.
`ifndef LED_MODE_BLINK_CONTROLLER_UNIT_MACROS_SVH
`define LED_MODE_BLINK_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTH
`define LMB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmb assertion failed");
`define LMB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmb assertion failed");
`else
`define LMB_ASSERT_IMPL(lbl, ante, cons)
`define LMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/lmb_pkg.sv
package lmb_pkg;

	localparam int IDX_W = 4;
	localparam int MAX_LEDS = 16;
	localparam int PIN_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [7:0] BUDGET_UNLIMITED = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIV = 1'b1;

	typedef enum logic [2:0] {
		CMD_SET_MODE    = 3'd0,
		CMD_REQ_BLINKS  = 3'd1,
		CMD_SET_BUDGET  = 3'd2,
		CMD_ADD_BUDGET  = 3'd3,
		CMD_PERIOD_TICK = 3'd4,
		CMD_OFF_TICK    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_SLOW = 2'd1,
		MODE_FAST = 2'd2,
		MODE_ON   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CELL_NONE     = 2'd0,
		CELL_SET_MODE = 2'd1,
		CELL_SET_PEND = 2'd2,
		CELL_OFF_TICK = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] index;
		mode_t            mode;
		logic [7:0]       amount;
	} cell_ctl_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] budget;
		logic       phase_zero;
	} tok_t;

endpackage

>>> sv/lmb_if.sv
interface lmb_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [3:0] led_index;
	logic [1:0] mode_value;
	logic [7:0] amount;

	modport source (output valid, command, led_index, mode_value, amount, input ready);
	modport sink (input valid, command, led_index, mode_value, amount, output ready);
endinterface

interface lmb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pin_levels;
	logic [7:0] budget_left;
	logic       request_taken;

	modport source (output valid, pin_levels, budget_left, request_taken, input ready);
	modport sink (input valid, pin_levels, budget_left, request_taken, output ready);
endinterface

>>> sv/lmb_cell.sv
module lmb_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lmb_pkg::cell_ctl_t ctl,
	input  logic              on_level,
	input  lmb_pkg::tok_t     tok_in,
	output lmb_pkg::tok_t     tok_out,
	output lmb_pkg::mode_t    mode,
	output logic              pin
);
	import lmb_pkg::*;

	mode_t      mode_q;
	logic [7:0] pend_q;
	logic       pin_q;
	tok_t       tok_q;
	logic       hit;
	logic       lit_blink;
	logic [7:0] budget_nx;

	assign hit = (ctl.index == IDX_W'(IDX));
	assign lit_blink = (mode_q == MODE_OFF) && (pend_q != 8'd0) && (tok_in.budget != 8'd0);
	assign budget_nx = (lit_blink && (tok_in.budget != BUDGET_UNLIMITED)) ?
		tok_in.budget - 8'd1 : tok_in.budget;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			pend_q <= 8'd0;
			pin_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.budget <= budget_nx;
			tok_q.phase_zero <= tok_in.phase_zero;
			priority if (tok_in.valid) begin
				unique case (mode_q)
					MODE_OFF: begin
						if (lit_blink) begin
							pin_q <= on_level;
							pend_q <= pend_q - 8'd1;
						end else begin
							pin_q <= ~on_level;
						end
					end
					MODE_SLOW: pin_q <= tok_in.phase_zero ? on_level : ~on_level;
					default: pin_q <= on_level;
				endcase
			end else begin
				unique case (ctl.op)
					CELL_SET_MODE: begin
						if (hit) begin
							mode_q <= ctl.mode;
							pend_q <= 8'd0;
						end
					end
					CELL_SET_PEND: begin
						if (hit) begin
							pend_q <= ctl.amount;
						end
					end
					CELL_OFF_TICK: begin
						if (mode_q != MODE_ON) begin
							pin_q <= ~on_level;
						end
					end
					CELL_NONE: ;
				endcase
			end
		end
	end

	assign tok_out = tok_q;
	assign mode = mode_q;
	assign pin = pin_q;

endmodule

>>> sv/led_mode_blink_controller_unit.sv
// LED blink controller: one cell per LED, each holding its mode, pending
// blink count and pin level.
// Commands arrive as beats on cmd_in; each command returns exactly one beat
// on res_out carrying the pin levels, the shared budget and request_taken,
// all as they stand after the command.
// Mode, blink request, budget and off-tick commands pass through the report
// state before their result beat is registered. A period tick instead
// sends the budget down the row of cells one cell per cycle, so that LEDs
// with a lower index draw on it first; its result beat is registered when
// the budget leaves the last cell.
// One command is in work at a time; the next is not accepted before the
// result of the one in work has been registered.
// The result register holds its beat while res_out.ready is low, and no new
// command is accepted until that beat has been taken.
// Configuration writes through cfg_we, cfg_index and cfg_data go straight
// into their registers and should be made while the block is idle.
// Reset puts every LED in off mode with no pending blinks and a dark pin,
// clears the budget and the slow phase, and restores the on-level mask to
// all ones and the slow divider to 6.
module led_mode_blink_controller_unit #(
	parameter int LED_COUNT = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	lmb_in_if.sink                         cmd_in,
	lmb_out_if.source                      res_out
);
	import lmb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REPORT = 3'b010,
		ST_SWEEP  = 3'b100
	} state_t;

	state_t      state_q;
	logic [7:0]  mask_q;
	logic [7:0]  div_q;
	logic [7:0]  budget_q;
	logic [7:0]  phase_q;
	logic        taken_q;
	tok_t        tok0_q;
	logic        out_valid_q;
	logic [7:0]  out_pins_q;
	logic [7:0]  out_budget_q;
	logic        out_taken_q;

	tok_t        tok_c [LED_COUNT+1];
	mode_t       modes16 [MAX_LEDS];
	logic [LED_COUNT-1:0] pins;
	logic [LED_COUNT-1:0] on_lvl;
	logic [LED_COUNT:0]   tok_v;
	logic [PIN_W-1:0]     pins_rep;

	cell_ctl_t   ctl;
	cmd_t        cmd;
	logic        accept;
	logic        idx_ok;
	logic        taken;
	logic [7:0]  phase_inc;
	logic        res_load;

	assign cmd = cmd_t'(cmd_in.command);
	assign accept = cmd_in.valid && cmd_in.ready;
	assign cmd_in.ready = (state_q == ST_IDLE) && (!out_valid_q || res_out.ready);
	assign idx_ok = ({1'b0, cmd_in.led_index} < (IDX_W + 1)'(LED_COUNT));
	assign phase_inc = phase_q + 8'd1;
	assign res_load = (state_q == ST_REPORT) ||
		((state_q == ST_SWEEP) && tok_c[LED_COUNT].valid);

	always_comb begin
		ctl.op = CELL_NONE;
		ctl.index = cmd_in.led_index;
		ctl.mode = mode_t'(cmd_in.mode_value);
		ctl.amount = cmd_in.amount;
		taken = 1'b0;
		if (accept) begin
			unique case (cmd)
				CMD_SET_MODE: begin
					if (idx_ok) begin
						ctl.op = CELL_SET_MODE;
						taken = 1'b1;
					end
				end
				CMD_REQ_BLINKS: begin
					if (idx_ok && (budget_q != 8'd0) &&
						(modes16[cmd_in.led_index] == MODE_OFF)) begin
						ctl.op = CELL_SET_PEND;
						taken = 1'b1;
					end
				end
				CMD_OFF_TICK: ctl.op = CELL_OFF_TICK;
				default: ;
			endcase
		end
	end

	assign tok_c[0] = tok0_q;
	assign tok_v[0] = tok0_q.valid;

	for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
		if (i < PIN_W) begin : g_lvl_mask
			assign on_lvl[i] = mask_q[i];
		end else begin : g_lvl_high
			assign on_lvl[i] = 1'b1;
		end
		lmb_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.on_level (on_lvl[i]),
			.tok_in   (tok_c[i]),
			.tok_out  (tok_c[i+1]),
			.mode     (modes16[i]),
			.pin      (pins[i])
		);
		assign tok_v[i+1] = tok_c[i+1].valid;
	end

	for (genvar i = LED_COUNT; i < MAX_LEDS; i++) begin : g_pad
		assign modes16[i] = MODE_ON;
	end

	for (genvar i = 0; i < PIN_W; i++) begin : g_rep
		if (i < LED_COUNT) begin : g_used
			assign pins_rep[i] = pins[i];
		end else begin : g_unused
			assign pins_rep[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 8'hFF;
			div_q <= 8'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_LEVEL: mask_q <= cfg_data;
				REG_SLOW_DIV: div_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			budget_q <= 8'd0;
			phase_q <= 8'd0;
			taken_q <= 1'b0;
			tok0_q <= '0;
			out_valid_q <= 1'b0;
			out_pins_q <= 8'd0;
			out_budget_q <= 8'd0;
			out_taken_q <= 1'b0;
		end else begin
			tok0_q.valid <= accept && (cmd == CMD_PERIOD_TICK);
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						taken_q <= taken;
						state_q <= (cmd == CMD_PERIOD_TICK) ? ST_SWEEP : ST_REPORT;
						unique case (cmd)
							CMD_SET_BUDGET: budget_q <= cmd_in.amount;
							CMD_ADD_BUDGET: begin
								if (budget_q != BUDGET_UNLIMITED) begin
									budget_q <= budget_q + 8'd1;
								end
							end
							CMD_PERIOD_TICK: begin
								tok0_q.budget <= budget_q;
								tok0_q.phase_zero <= (phase_q == 8'd0);
								phase_q <= (phase_inc == div_q) ? 8'd0 : phase_inc;
							end
							default: ;
						endcase
					end
				end
				ST_REPORT: begin
					out_pins_q <= pins_rep;
					out_budget_q <= budget_q;
					out_taken_q <= taken_q;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (tok_c[LED_COUNT].valid) begin
						budget_q <= tok_c[LED_COUNT].budget;
						out_pins_q <= pins_rep;
						out_budget_q <= tok_c[LED_COUNT].budget;
						out_taken_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.pin_levels = out_pins_q;
	assign res_out.budget_left = out_budget_q;
	assign res_out.request_taken = out_taken_q;

`include "led_mode_blink_controller_unit_macros.svh"

	`LMB_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(tok_v))
	`LMB_ASSERT_IMPL(a_token_in_sweep, tok_v != '0, state_q == ST_SWEEP)
	`LMB_ASSERT_NEXT(a_tick_launch, accept && (cmd == CMD_PERIOD_TICK),
		tok0_q.valid && (state_q == ST_SWEEP))

endmodule
